/* hw/rtl/ddo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// shared types, constants and helpers of the wheel odometry core
// ----------------------------------------------------------------------------
package ddo_pkg;

	localparam int unsigned CORDIC_STEPS = 30;
	localparam logic [63:0] ANG_SCALE = 64'd2935890503282001227;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
	localparam logic signed [57:0] POSE_MAX = 58'sd140737488355327;
	localparam logic signed [57:0] POSE_MIN = -58'sd140737488355328;

	localparam logic [31:0] MPT_RESET = 32'd52976469;
	localparam logic [31:0] INV_DIST_RESET = 32'd187874759;

	// configuration register indexes
	localparam logic [1:0] REG_MPT_LEFT = 2'd0;
	localparam logic [1:0] REG_MPT_RIGHT = 2'd1;
	localparam logic [1:0] REG_INV_DIST = 2'd2;

	localparam logic ACTION_RESTART = 1'b0;

	typedef enum logic [5:0] {
		ST_IDLE, ST_RESTART, ST_WL, ST_WR, ST_TR, ST_SUM,
		ST_RAD0, ST_RAD1, ST_RAD2, ST_RADL,
		ST_ANG0, ST_ANG1, ST_ANG2, ST_ANG3, ST_ANG4, ST_HEAD,
		ST_CORD, ST_FOLD,
		ST_X0, ST_X1, ST_X2, ST_XAD,
		ST_Y0, ST_Y1, ST_Y2, ST_YAD,
		ST_WB
	} state_t;

	// operand pair of the shared multiplier
	typedef enum logic [3:0] {
		MOP_NONE, MOP_WL, MOP_WR, MOP_RAD0, MOP_RAD1,
		MOP_ANG0, MOP_ANG1, MOP_ANG2, MOP_ANG3,
		MOP_X0, MOP_X1, MOP_Y0, MOP_Y1
	} mul_op_t;

	// product accumulator action
	typedef enum logic [1:0] {
		AOP_NONE, AOP_LOAD, AOP_ADD32, AOP_ADD64
	} acc_op_t;

	// register load action
	typedef enum logic [3:0] {
		LOP_NONE, LOP_CAPTURE, LOP_RESTART, LOP_TL, LOP_TR, LOP_SUM,
		LOP_RAD, LOP_HEAD, LOP_CORD, LOP_FOLD, LOP_X, LOP_Y, LOP_WB
	} load_op_t;

	typedef struct packed {
		mul_op_t mop;
		acc_op_t aop;
		load_op_t lop;
	} dp_cmd_t;

	typedef struct packed {
		logic cord_done;
	} dp_status_t;

	function automatic logic [31:0] atan_lookup(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [57:0] v);
		logic signed [47:0] r;
		if (v > POSE_MAX) begin
			r = POSE_MAX[47:0];
		end else if (v < POSE_MIN) begin
			r = POSE_MIN[47:0];
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/ddo_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_req_if
// encoder count request channel
// ----------------------------------------------------------------------------
interface ddo_req_if;
	logic valid;
	logic ready;
	logic action;
	logic signed [31:0] count_left;
	logic signed [31:0] count_right;

	modport source (output valid, action, count_left, count_right, input ready);
	modport sink (input valid, action, count_left, count_right, output ready);
endinterface

/* hw/rtl/ddo_pose_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pose_if
// pose result channel
// ----------------------------------------------------------------------------
interface ddo_pose_if;
	logic valid;
	logic ready;
	logic signed [47:0] pose_x;
	logic signed [47:0] pose_y;
	logic signed [31:0] heading;

	modport source (output valid, pose_x, pose_y, heading, input ready);
	modport sink (input valid, pose_x, pose_y, heading, output ready);
endinterface

/* hw/rtl/ddo_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_cfg_if
// configuration register write channel
// ----------------------------------------------------------------------------
interface ddo_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/ddo_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_ctrl
// sequencer of the odometry datapath
// ----------------------------------------------------------------------------
module ddo_ctrl
	import ddo_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_action,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input dp_status_t status,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;
	logic out_valid_q;
	logic wb_go;

	assign wb_go = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_action == ACTION_RESTART) ? ST_RESTART : ST_WL;
				end
			end
			ST_RESTART: state_d = ST_WB;
			ST_WL: state_d = ST_WR;
			ST_WR: state_d = ST_TR;
			ST_TR: state_d = ST_SUM;
			ST_SUM: state_d = ST_RAD0;
			ST_RAD0: state_d = ST_RAD1;
			ST_RAD1: state_d = ST_RAD2;
			ST_RAD2: state_d = ST_RADL;
			ST_RADL: state_d = ST_ANG0;
			ST_ANG0: state_d = ST_ANG1;
			ST_ANG1: state_d = ST_ANG2;
			ST_ANG2: state_d = ST_ANG3;
			ST_ANG3: state_d = ST_ANG4;
			ST_ANG4: state_d = ST_HEAD;
			ST_HEAD: state_d = ST_CORD;
			ST_CORD: begin
				if (status.cord_done) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: state_d = ST_X0;
			ST_X0: state_d = ST_X1;
			ST_X1: state_d = ST_X2;
			ST_X2: state_d = ST_XAD;
			ST_XAD: state_d = ST_Y0;
			ST_Y0: state_d = ST_Y1;
			ST_Y1: state_d = ST_Y2;
			ST_Y2: state_d = ST_YAD;
			ST_YAD: state_d = ST_WB;
			ST_WB: begin
				if (wb_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.mop = MOP_NONE;
		cmd.aop = AOP_NONE;
		cmd.lop = LOP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.lop = LOP_CAPTURE;
				end
			end
			ST_RESTART: cmd.lop = LOP_RESTART;
			ST_WL: cmd.mop = MOP_WL;
			ST_WR: begin
				cmd.mop = MOP_WR;
				cmd.lop = LOP_TL;
			end
			ST_TR: cmd.lop = LOP_TR;
			ST_SUM: cmd.lop = LOP_SUM;
			ST_RAD0: cmd.mop = MOP_RAD0;
			ST_RAD1: begin
				cmd.mop = MOP_RAD1;
				cmd.aop = AOP_LOAD;
			end
			ST_RAD2: cmd.aop = AOP_ADD32;
			ST_RADL: cmd.lop = LOP_RAD;
			ST_ANG0: cmd.mop = MOP_ANG0;
			ST_ANG1: begin
				cmd.mop = MOP_ANG1;
				cmd.aop = AOP_LOAD;
			end
			ST_ANG2: begin
				cmd.mop = MOP_ANG2;
				cmd.aop = AOP_ADD32;
			end
			ST_ANG3: begin
				cmd.mop = MOP_ANG3;
				cmd.aop = AOP_ADD32;
			end
			ST_ANG4: cmd.aop = AOP_ADD64;
			ST_HEAD: cmd.lop = LOP_HEAD;
			ST_CORD: cmd.lop = LOP_CORD;
			ST_FOLD: cmd.lop = LOP_FOLD;
			ST_X0: cmd.mop = MOP_X0;
			ST_X1: begin
				cmd.mop = MOP_X1;
				cmd.aop = AOP_LOAD;
			end
			ST_X2: cmd.aop = AOP_ADD32;
			ST_XAD: cmd.lop = LOP_X;
			ST_Y0: cmd.mop = MOP_Y0;
			ST_Y1: begin
				cmd.mop = MOP_Y1;
				cmd.aop = AOP_LOAD;
			end
			ST_Y2: cmd.aop = AOP_ADD32;
			ST_YAD: cmd.lop = LOP_Y;
			ST_WB: begin
				if (wb_go) begin
					cmd.lop = LOP_WB;
				end
			end
			default: cmd.lop = LOP_NONE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WB && wb_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/ddo_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_dp
// odometry datapath: shared 32x32 multiplier, accumulator, cordic, pose
// ----------------------------------------------------------------------------
module ddo_dp
	import ddo_pkg::*;
#(
	parameter int unsigned ENCODER_WIDTH = 32
)
(
	input logic clk,
	input logic arst_n,
	input dp_cmd_t cmd,
	output dp_status_t status,
	input logic signed [31:0] count_left,
	input logic signed [31:0] count_right,
	input logic [31:0] mpt_left,
	input logic [31:0] mpt_right,
	input logic [31:0] inv_dist,
	output logic signed [47:0] pose_x,
	output logic signed [47:0] pose_y,
	output logic signed [31:0] heading
);

	localparam int unsigned ESH = 32 - ENCODER_WIDTH;

	logic [31:0] in_left_q, in_right_q, last_left_q, last_right_q;
	logic [31:0] raw_l, raw_r;
	logic signed [31:0] dl, dr;
	logic [31:0] dl_mag, dr_mag;
	logic dl_neg_q, dr_neg_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] pp_q;
	logic [127:0] acc_q;

	logic signed [55:0] tl_q, tr_q;
	logic signed [63:0] tw;
	logic signed [56:0] tsum, tdiff;
	logic signed [55:0] s_val;
	logic [55:0] s_mag_q;
	logic s_neg_q;
	logic [56:0] dm_q;
	logic dneg_q;
	logic [63:0] rad_q;

	logic [31:0] dth_q, heading_q;
	logic [31:0] m_lo, half_raw, half, mid, ru;
	logic [1:0] quad, quad_q;

	logic signed [33:0] cx_q, cy_q, cz_q, xs, ys, atn;
	logic [4:0] it_q;
	logic signed [33:0] fc, fs;
	logic [33:0] fc_mag, fs_mag;
	logic [31:0] cmag_q, snmag_q;
	logic cneg_q, snneg_q;

	logic [56:0] r57;
	logic signed [57:0] sval, pose_sum;
	logic signed [47:0] pose_x_q, pose_y_q;
	logic signed [47:0] out_x_q, out_y_q;
	logic [31:0] out_h_q;

	// wrapped count differences at the encoder width
	assign raw_l = in_left_q - last_left_q;
	assign raw_r = in_right_q - last_right_q;
	always_comb begin
		dl = $signed(raw_l << ESH) >>> ESH;
		dr = $signed(raw_r << ESH) >>> ESH;
		dl_mag = dl[31] ? 32'(-dl) : dl;
		dr_mag = dr[31] ? 32'(-dr) : dr;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mop)
			MOP_WL: begin mul_a = dl_mag; mul_b = mpt_left; end
			MOP_WR: begin mul_a = dr_mag; mul_b = mpt_right; end
			MOP_RAD0: begin mul_a = dm_q[31:0]; mul_b = inv_dist; end
			MOP_RAD1: begin mul_a = {7'd0, dm_q[56:32]}; mul_b = inv_dist; end
			MOP_ANG0: begin mul_a = rad_q[31:0]; mul_b = ANG_SCALE[31:0]; end
			MOP_ANG1: begin mul_a = rad_q[31:0]; mul_b = ANG_SCALE[63:32]; end
			MOP_ANG2: begin mul_a = rad_q[63:32]; mul_b = ANG_SCALE[31:0]; end
			MOP_ANG3: begin mul_a = rad_q[63:32]; mul_b = ANG_SCALE[63:32]; end
			MOP_X0: begin mul_a = s_mag_q[31:0]; mul_b = cmag_q; end
			MOP_X1: begin mul_a = {8'd0, s_mag_q[55:32]}; mul_b = cmag_q; end
			MOP_Y0: begin mul_a = s_mag_q[31:0]; mul_b = snmag_q; end
			MOP_Y1: begin mul_a = {8'd0, s_mag_q[55:32]}; mul_b = snmag_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// signed wheel travel and the sums built from it
	always_comb begin
		tw = dl_neg_q ? -$signed(pp_q) : $signed(pp_q);
		if (cmd.lop == LOP_TR) begin
			tw = dr_neg_q ? -$signed(pp_q) : $signed(pp_q);
		end
		tsum = {tl_q[55], tl_q} + {tr_q[55], tr_q};
		tdiff = {tl_q[55], tl_q} - {tr_q[55], tr_q};
		s_val = tsum[56:1];
	end

	// heading change and midpoint angle
	always_comb begin
		m_lo = acc_q[95:64];
		half_raw = acc_q[96:65];
		half = dneg_q ? 32'(-half_raw) : half_raw;
		mid = heading_q + half;
		quad = 2'((mid + 32'h20000000) >> 30);
		ru = mid - {quad, 30'd0};
	end

	always_comb begin
		xs = cx_q >>> it_q;
		ys = cy_q >>> it_q;
		atn = $signed({2'b00, atan_lookup(it_q)});
	end

	always_comb begin
		case (quad_q)
			2'd0: begin fc = cx_q; fs = cy_q; end
			2'd1: begin fc = -cy_q; fs = cx_q; end
			2'd2: begin fc = -cx_q; fs = -cy_q; end
			default: begin fc = cy_q; fs = -cx_q; end
		endcase
		fc_mag = fc[33] ? 34'(-fc) : fc;
		fs_mag = fs[33] ? 34'(-fs) : fs;
	end

	// scaled move and saturating pose update
	always_comb begin
		r57 = acc_q[86:30];
		if (cmd.lop == LOP_X) begin
			sval = (s_neg_q ^ cneg_q) ? -$signed({1'b0, r57}) : $signed({1'b0, r57});
			pose_sum = {{10{pose_x_q[47]}}, pose_x_q} + sval;
		end else begin
			sval = (s_neg_q ^ snneg_q) ? -$signed({1'b0, r57}) : $signed({1'b0, r57});
			pose_sum = {{10{pose_y_q[47]}}, pose_y_q} + sval;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mop != MOP_NONE) begin
			pp_q <= mul_a * mul_b;
		end
		case (cmd.aop)
			AOP_LOAD: acc_q <= {64'd0, pp_q};
			AOP_ADD32: acc_q <= acc_q + {32'd0, pp_q, 32'd0};
			AOP_ADD64: acc_q <= acc_q + {pp_q, 64'd0};
			default: acc_q <= acc_q;
		endcase
		case (cmd.lop)
			LOP_CAPTURE: begin
				in_left_q <= count_left;
				in_right_q <= count_right;
			end
			LOP_TL: tl_q <= tw[63:8];
			LOP_TR: tr_q <= tw[63:8];
			LOP_SUM: begin
				s_neg_q <= s_val[55];
				s_mag_q <= s_val[55] ? 56'(-s_val) : s_val;
				dneg_q <= tdiff[56];
				dm_q <= tdiff[56] ? 57'(-tdiff) : tdiff;
			end
			LOP_RAD: rad_q <= acc_q[87:24];
			LOP_HEAD: begin
				dth_q <= dneg_q ? 32'(-m_lo) : m_lo;
				quad_q <= quad;
				cz_q <= {{2{ru[31]}}, ru};
				cx_q <= CORDIC_X0;
				cy_q <= '0;
				it_q <= '0;
			end
			LOP_CORD: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - atn;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + atn;
				end
				it_q <= it_q + 5'd1;
			end
			LOP_FOLD: begin
				cneg_q <= fc[33];
				snneg_q <= fs[33];
				cmag_q <= fc_mag[31:0];
				snmag_q <= fs_mag[31:0];
			end
			LOP_WB: begin
				out_x_q <= pose_x_q;
				out_y_q <= pose_y_q;
				out_h_q <= heading_q;
			end
			default: begin
			end
		endcase
		if (cmd.mop == MOP_WL) begin
			dl_neg_q <= dl[31];
			dr_neg_q <= dr[31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_left_q <= '0;
			last_right_q <= '0;
			pose_x_q <= '0;
			pose_y_q <= '0;
			heading_q <= '0;
		end else begin
			case (cmd.lop)
				LOP_RESTART: begin
					pose_x_q <= '0;
					pose_y_q <= '0;
					heading_q <= '0;
				end
				LOP_X: pose_x_q <= sat48(pose_sum);
				LOP_Y: begin
					pose_y_q <= sat48(pose_sum);
					heading_q <= heading_q + dth_q;
				end
				LOP_WB: begin
					last_left_q <= in_left_q;
					last_right_q <= in_right_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign status.cord_done = (it_q == 5'(CORDIC_STEPS - 1));
	assign pose_x = out_x_q;
	assign pose_y = out_y_q;
	assign heading = $signed(out_h_q);

endmodule

/* hw/rtl/differential_drive_odometry_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// fixed-point differential-drive wheel odometry, midpoint rule
// ----------------------------------------------------------------------------
// usage
//   odo_in   : request with action and both wheel encoder counts; action 0
//              restarts tracking (stores counts, clears pose), action 1
//              integrates one step against the stored counts
//   pose_out : one pose per request (x, y in Q16.32 m, heading binary angle)
//   cfg      : register writes, index 0/1 metres per tick left/right,
//              index 2 reciprocal axle length; index 3 is ignored; always ready
// timing
//   a step request runs the full state sequence, a restart only its clear and
//   write-back states; one request is in work at a time, so a new request can be
//   taken in the cycle after the previous pose has been registered
//   the step time is set by the 30-iteration cordic and the single shared
//   32x32 multiplier, which is used for 12 partial products per step
// reset
//   pose, stored counts and handshake state clear; registers take defaults
// stall
//   the pose register holds until taken; a new request can be accepted while
//   it waits, and its result is held back until the register is free
// ----------------------------------------------------------------------------
module differential_drive_odometry_core
	import ddo_pkg::*;
#(
	parameter int unsigned ENCODER_WIDTH = 32
)
(
	input logic clk,
	input logic arst_n,
	ddo_req_if.sink odo_in,
	ddo_pose_if.source pose_out,
	ddo_cfg_if.sink cfg
);

	logic [31:0] mpt_left_q, mpt_right_q, inv_dist_q;
	dp_cmd_t cmd;
	dp_status_t status;

	// configuration registers, to be written only while idle; the block does not enforce it
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpt_left_q <= MPT_RESET;
			mpt_right_q <= MPT_RESET;
			inv_dist_q <= INV_DIST_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MPT_LEFT: mpt_left_q <= cfg.data;
				REG_MPT_RIGHT: mpt_right_q <= cfg.data;
				REG_INV_DIST: inv_dist_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	ddo_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(odo_in.valid),
		.in_action(odo_in.action),
		.in_ready(odo_in.ready),
		.out_valid(pose_out.valid),
		.out_ready(pose_out.ready),
		.status(status),
		.cmd(cmd)
	);

	// arithmetic and pose state
	ddo_dp #(
		.ENCODER_WIDTH(ENCODER_WIDTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.count_left(odo_in.count_left),
		.count_right(odo_in.count_right),
		.mpt_left(mpt_left_q),
		.mpt_right(mpt_right_q),
		.inv_dist(inv_dist_q),
		.pose_x(pose_out.pose_x),
		.pose_y(pose_out.pose_y),
		.heading(pose_out.heading)
	);

endmodule

/* bench/differential_drive_odometry_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_core_tb
// self-checking bench for the wheel odometry core
// ----------------------------------------------------------------------------
// encoder count requests are queued by the stimulus process and driven in
// random bursts; every request is run through a local pose tracker when it is
// accepted, and each pose that leaves the core is compared with the oldest
// predicted pose. register settings change between phases, only while idle.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core_tb
	import ddo_pkg::*;
;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int unsigned HOLD_AFTER = 400;
	localparam int unsigned DRAIN_CYCLES = 80;
	localparam int unsigned ITEMS_PER_PHASE = 310;
	localparam logic ACTION_STEP = 1'b1;
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef struct {
		logic act;
		logic [31:0] pl;
		logic [31:0] pr;
	} odo_req_t;

	typedef struct {
		logic [47:0] x;
		logic [47:0] y;
		logic [31:0] h;
	} pose_t;

	logic clk;
	logic arst_n;

	ddo_req_if odo_in ();
	ddo_pose_if pose_out ();
	ddo_cfg_if cfg ();

	differential_drive_odometry_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.odo_in(odo_in.sink),
		.pose_out(pose_out.source),
		.cfg(cfg.sink)
	);

	// request queue and predicted poses
	odo_req_t pending_reqs[$];
	pose_t expected_poses[$];

	// local copy of the registers and tracking state
	logic [31:0] trk_mpt_l;
	logic [31:0] trk_mpt_r;
	logic [31:0] trk_inv;
	logic [31:0] trk_last_l;
	logic [31:0] trk_last_r;
	logic signed [47:0] trk_x;
	logic signed [47:0] trk_y;
	logic [31:0] trk_h;

	// arctangent table, binary angle units
	logic [31:0] atan_rom [30];

	// generator's view of the last counts sent
	logic [31:0] gen_last_l;
	logic [31:0] gen_last_r;

	int unsigned errors;
	int unsigned n_steps;
	int unsigned n_restarts;
	int unsigned n_cfg;
	int unsigned n_sat;
	int unsigned n_poses;
	int unsigned n_req_acc;
	int unsigned idle_cycles;
	bit stim_done;

	// ------------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------------
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// ------------------------------------------------------------------------
	// pose tracker
	// ------------------------------------------------------------------------

	// v * f / 2^30 with the magnitude truncated
	function automatic logic signed [71:0] mul_q30(input logic signed [71:0] v,
			input logic signed [63:0] f);
		logic [71:0] mv;
		logic [63:0] mf;
		logic [127:0] prod;
		logic [71:0] r;
		mv = v[71] ? -v : v;
		mf = f[63] ? -f : f;
		prod = {56'd0, mv} * {64'd0, mf};
		r = {8'd0, prod[93:30]};
		return (v[71] != f[63]) ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [47:0] clamp48(input logic signed [71:0] v);
		if (v > 72'sd140737488355327) begin
			n_sat++;
			return 48'sh7FFFFFFFFFFF;
		end else if (v < -72'sd140737488355328) begin
			n_sat++;
			return 48'sh800000000000;
		end
		return v[47:0];
	endfunction

	// cos and sin of a binary angle, q2.30
	task automatic rotate_vector(input logic [31:0] ang, output logic signed [63:0] c,
			output logic signed [63:0] s);
		logic [31:0] biased;
		logic [1:0] q;
		logic [31:0] ru;
		logic signed [63:0] z, x, y, xs, ys;
		biased = ang + 32'h20000000;
		q = biased[31:30];
		ru = ang - {q, 30'd0};
		z = {{32{ru[31]}}, ru};
		x = 64'(CORDIC_X0);
		y = 0;
		for (int i = 0; i < 30; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - $signed({32'd0, atan_rom[i]});
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + $signed({32'd0, atan_rom[i]});
			end
		end
		case (q)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	task automatic track_pose(input odo_req_t r, output pose_t p);
		logic signed [31:0] dl, dr;
		logic signed [71:0] tl, tr, sum_half, diff;
		logic [71:0] mag;
		logic [127:0] prod;
		logic [63:0] rad, turn;
		logic [31:0] dth, half, mid;
		logic signed [63:0] c, s;
		if (r.act == ACTION_RESTART) begin
			trk_x = 0;
			trk_y = 0;
			trk_h = 0;
			n_restarts++;
		end else begin
			dl = r.pl - trk_last_l;
			dr = r.pr - trk_last_r;
			tl = (72'(dl) * $signed({40'd0, trk_mpt_l})) >>> 8;
			tr = (72'(dr) * $signed({40'd0, trk_mpt_r})) >>> 8;
			sum_half = (tl + tr) >>> 1;
			diff = tl - tr;
			mag = diff[71] ? -diff : diff;
			prod = {56'd0, mag} * {96'd0, trk_inv};
			rad = prod[87:24];
			prod = {64'd0, rad} * {64'd0, ANG_SCALE};
			turn = prod[127:64];
			if (diff[71]) begin
				dth = -turn[31:0];
				half = -turn[32:1];
			end else begin
				dth = turn[31:0];
				half = turn[32:1];
			end
			mid = trk_h + half;
			rotate_vector(mid, c, s);
			trk_x = clamp48(72'(trk_x) + mul_q30(sum_half, c));
			trk_y = clamp48(72'(trk_y) + mul_q30(sum_half, s));
			trk_h = trk_h + dth;
			n_steps++;
		end
		trk_last_l = r.pl;
		trk_last_r = r.pr;
		p.x = trk_x;
		p.y = trk_y;
		p.h = trk_h;
	endtask

	// ------------------------------------------------------------------------
	// request driver: bursts of random length, random gaps between them
	// ------------------------------------------------------------------------
	int unsigned burst_left;
	int unsigned gap_left;
	odo_req_t drv_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odo_in.valid <= 1'b0;
			odo_in.action <= 1'b0;
			odo_in.count_left <= '0;
			odo_in.count_right <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!odo_in.valid || odo_in.ready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				odo_in.valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				drv_item = pending_reqs.pop_front();
				odo_in.valid <= 1'b1;
				odo_in.action <= drv_item.act;
				odo_in.count_left <= drv_item.pl;
				odo_in.count_right <= drv_item.pr;
				if (burst_left <= 1) begin
					// new burst; a quarter of the bursts come back to back
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				odo_in.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// pose receiver: stall pattern changes at random times, with one
	// long hold-off so that the core backs up and stalls its request side
	// ------------------------------------------------------------------------
	int unsigned stall_mode;
	int unsigned mode_left;
	int unsigned hold_left;
	bit hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_out.ready <= 1'b0;
			stall_mode <= 0;
			mode_left <= 300;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(100, 800);
			end else begin
				mode_left <= mode_left - 1;
			end
			if (!hold_done && n_req_acc >= HOLD_AFTER) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				pose_out.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				pose_out.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: pose_out.ready <= 1'b1;
					1: pose_out.ready <= $urandom_range(0, 1);
					2: pose_out.ready <= ($urandom_range(0, 7) == 0);
					default: pose_out.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: predict on each accepted request, check each accepted pose
	// ------------------------------------------------------------------------
	odo_req_t mon_req;
	pose_t mon_pose;
	pose_t mon_exp;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MPT_LEFT: trk_mpt_l = cfg.data;
					REG_MPT_RIGHT: trk_mpt_r = cfg.data;
					REG_INV_DIST: trk_inv = cfg.data;
					default: ; // unused index, write dropped
				endcase
				n_cfg++;
			end
			if (odo_in.valid && odo_in.ready) begin
				mon_req.act = odo_in.action;
				mon_req.pl = odo_in.count_left;
				mon_req.pr = odo_in.count_right;
				track_pose(mon_req, mon_pose);
				expected_poses.push_back(mon_pose);
				n_req_acc++;
			end
			if (pose_out.valid && pose_out.ready) begin
				n_poses++;
				if (expected_poses.size() == 0) begin
					$error("pose with no request outstanding: x %h y %h heading %h",
						pose_out.pose_x, pose_out.pose_y, pose_out.heading);
					errors++;
				end else begin
					mon_exp = expected_poses.pop_front();
					if (pose_out.pose_x !== mon_exp.x) begin
						$error("pose_x expected %h actual %h", mon_exp.x, pose_out.pose_x);
						errors++;
					end
					if (pose_out.pose_y !== mon_exp.y) begin
						$error("pose_y expected %h actual %h", mon_exp.y, pose_out.pose_y);
						errors++;
					end
					if (pose_out.heading !== mon_exp.h) begin
						$error("heading expected %h actual %h", mon_exp.h, pose_out.heading);
						errors++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long without any handshake ends the run
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (odo_in.valid && odo_in.ready) || (pose_out.valid && pose_out.ready)
				|| (cfg.valid && cfg.ready) || stim_done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d poses still awaited", expected_poses.size());
			$display("FAIL differential_drive_odometry_core");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	task automatic queue_req(input logic act, input logic [31:0] pl, input logic [31:0] pr);
		odo_req_t r;
		r.act = act;
		r.pl = pl;
		r.pr = pr;
		pending_reqs.push_back(r);
		gen_last_l = pl;
		gen_last_r = pr;
	endtask

	// count step relative to the last counts sent, mostly small
	function automatic logic [31:0] count_step(input logic [31:0] last);
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			return last + 32'($signed($urandom_range(0, 4000)) - 2000);
		end else if (sel < 80) begin
			return last + 32'($signed($urandom_range(0, 2000000)) - 1000000);
		end else if (sel < 90) begin
			return last;
		end else if (sel < 96) begin
			return $urandom();
		end
		case ($urandom_range(0, 3))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return last + 32'h7FFFFFFF;
			default: return last + 32'h80000000;
		endcase
	endfunction

	task automatic queue_random(input int unsigned n);
		logic [31:0] pl, pr;
		for (int unsigned i = 0; i < n; i++) begin
			pl = count_step(gen_last_l);
			// mostly both wheels alike, so the robot drives with gentle turns
			if ($urandom_range(0, 2) == 0) begin
				pr = count_step(gen_last_r);
			end else begin
				pr = gen_last_r + (pl - gen_last_l) + 32'($signed($urandom_range(0, 400)) - 200);
			end
			if ($urandom_range(0, 19) == 0) begin
				queue_req(ACTION_RESTART, pl, pr);
			end else begin
				queue_req(ACTION_STEP, pl, pr);
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// all requests taken and all poses back, then let the core settle
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || expected_poses.size() != 0 || odo_in.valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [31:0] mpt_l, input logic [31:0] mpt_r,
			input logic [31:0] inv);
		wait_idle();
		write_reg(REG_MPT_LEFT, mpt_l);
		write_reg(REG_MPT_RIGHT, mpt_r);
		write_reg(REG_INV_DIST, inv);
		queue_random(ITEMS_PER_PHASE);
	endtask

	initial begin
		atan_rom = '{
			32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
			32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
			32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
		trk_mpt_l = MPT_RESET;
		trk_mpt_r = MPT_RESET;
		trk_inv = INV_DIST_RESET;
		trk_last_l = 0;
		trk_last_r = 0;
		trk_x = 0;
		trk_y = 0;
		trk_h = 0;
		gen_last_l = 0;
		gen_last_r = 0;
		errors = 0;
		n_steps = 0;
		n_restarts = 0;
		n_cfg = 0;
		n_sat = 0;
		n_poses = 0;
		n_req_acc = 0;
		stim_done = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: step before any restart, against zero counts
		queue_req(ACTION_STEP, 32'd100, 32'd100);
		queue_req(ACTION_STEP, 32'd150, 32'd90);
		// restart clears the pose, registers stay
		queue_req(ACTION_RESTART, 32'h7FFFFFFF, 32'h80000000);
		// straight ahead, pure turns both ways, reverse
		queue_req(ACTION_STEP, 32'h80000063, 32'h80000063);
		queue_req(ACTION_STEP, 32'h800003E7, 32'h80000063);
		queue_req(ACTION_STEP, 32'h800003E7, 32'h800003E7);
		queue_req(ACTION_STEP, 32'h800001E7, 32'h800005E7);
		queue_req(ACTION_STEP, 32'h7FFFFFFF, 32'h7FFFFFFF);
		// largest count differences, wrapping both ways
		queue_req(ACTION_STEP, 32'hFFFFFFFE, 32'h7FFFFFFE);
		queue_req(ACTION_STEP, 32'h7FFFFFFE, 32'hFFFFFFFF);
		queue_req(ACTION_STEP, 32'h00000000, 32'h00000000);
		queue_req(ACTION_STEP, 32'h80000000, 32'h80000000);
		queue_req(ACTION_RESTART, 32'h00000000, 32'hFFFFFFFF);
		// spin on the spot until the heading wraps
		for (int i = 1; i <= 8; i++)
			queue_req(ACTION_STEP, 32'(i * 40000), 32'hFFFFFFFF - 32'(i * 40000));
		queue_random(ITEMS_PER_PHASE - 21);

		// zero scale, minimum distance reciprocal; the unused index is dropped
		wait_idle();
		write_reg(REG_NONE, 32'hFFFFFFFF);
		run_phase(32'd0, 32'd0, 32'd1);
		// largest values everywhere, drives the pose into saturation
		run_phase(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		// no heading change at all, unequal wheels
		run_phase(32'd80000000, 32'd20000000, 32'd0);
		// random settings
		run_phase($urandom(), $urandom(), $urandom());
		run_phase(32'($urandom_range(1, 200000000)), 32'($urandom_range(1, 200000000)),
			32'($urandom_range(1, 400000000)));
		wait_idle();
		stim_done = 1'b1;

		$display("covered %0d steps and %0d restarts over %0d register writes",
			n_steps, n_restarts, n_cfg);
		$display("%0d poses checked, %0d saturated position updates", n_poses, n_sat);
		if (errors == 0) begin
			$display("PASS differential_drive_odometry_core");
		end else begin
			$display("FAIL differential_drive_odometry_core");
		end
		$finish;
	end

endmodule
